/* rtl/core/prefix_expression_evaluator_assert.svh */
// assertion macros shared by the evaluator rtl
// expects clk and rst_n to be in scope where a macro is used
`ifndef PREFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define PREFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define PFX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pfx_eval_pkg.sv */
// types, codes and sizes for the prefix expression evaluator
// no dependencies
package pfx_eval_pkg;

    localparam int DATA_W          = 64;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int STEP_W          = $clog2(DATA_W);
    localparam int STATUS_W        = 3;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_OP   = 1'b1;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd4;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] operand_value;
        logic [1:0]               op_code;
        logic                     last_token;
    } pfx_eval_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [STATUS_W-1:0]      status;
    } pfx_eval_out_t;

endpackage

/* rtl/core/prefix_expression_evaluator.sv */
// prefix expression evaluator: value stack with one shared 65-bit add/sub unit
// depends on pfx_eval_pkg, pfx_eval_ram and prefix_expression_evaluator_assert.svh
//
//  channel   dir  payload          handshake
//  token     in   pfx_eval_in_t    token_valid / token_stall
//  result    out  pfx_eval_out_t   result_valid / result_stall
//
// multiply and divide run one bit per cycle through the shared add/sub unit
// top of stack lives in a register, the rest in a ram, so an operator needs one ram read
// rst_n clears stack count, error and result valid; no ram clearing pass
// a finished word sits in the result register; the final token of the next
// expression waits for it only if the result side is still stalling
`include "prefix_expression_evaluator_assert.svh"

module prefix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_eval_pkg::STACK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        token_valid,
    output logic                        token_stall,
    input  pfx_eval_pkg::pfx_eval_in_t  token,
    output logic                        result_valid,
    input  logic                        result_stall,
    output pfx_eval_pkg::pfx_eval_out_t result
);

    import pfx_eval_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_DIVA = 9'b000001000,
        S_DIVB = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_FIX  = 9'b001000000,
        S_DONE = 9'b010000000,
        S_WAIT = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] error_reg, error_next;
    logic                out_valid_reg, out_valid_next;
    pfx_eval_out_t       out_reg, out_next;

    logic [DATA_W-1:0]   top_reg, top_next;
    logic [DATA_W-1:0]   opa_reg, opa_next;
    logic [DATA_W-1:0]   opb_reg, opb_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [1:0]          op_reg, op_next;
    logic                last_reg, last_next;

    logic [DATA_W:0]     alu_a, alu_b, alu_y;
    logic                alu_sub;

    logic                ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    logic                token_fire, out_free;

    pfx_eval_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (top_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign token_stall  = (state_reg != S_IDLE);
    assign token_fire   = token_valid && (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // shared add/sub unit
    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + {{DATA_W{1'b0}}, alu_sub};

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_READ:
            begin
                alu_a   = {1'b0, top_reg};
                alu_b   = {1'b0, ram_rd_data};
                alu_sub = (op_reg == OP_SUB);
            end
            S_MUL:
            begin
                alu_a = {1'b0, acc_reg};
                alu_b = {1'b0, opa_reg};
            end
            S_DIVA, S_FIX:
            begin
                alu_b   = {1'b0, opa_reg};
                alu_sub = 1'b1;
            end
            S_DIVB:
            begin
                alu_b   = {1'b0, opb_reg};
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = {acc_reg, opa_reg[DATA_W-1]};
                alu_b   = {1'b0, opb_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        error_next     = error_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        top_next       = top_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = ADDR_W'(count_reg - CNT_W'(1));
        ram_rd_en      = 1'b0;
        ram_rd_addr    = ADDR_W'(count_reg - CNT_W'(2));

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (token_fire)
                begin
                    op_next    = token.op_code;
                    last_next  = token.last_token;
                    state_next = S_DONE;
                    if (error_reg != ST_OK)
                    begin
                        state_next = S_DONE;
                    end
                    else if (token.mode == MODE_PUSH)
                    begin
                        if (count_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            error_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            ram_wr_en  = (count_reg != '0);
                            top_next   = token.operand_value;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg < CNT_W'(2))
                    begin
                        error_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                opa_next  = top_reg;
                opb_next  = ram_rd_data;
                acc_next  = '0;
                step_next = '0;
                neg_next  = top_reg[DATA_W-1] ^ ram_rd_data[DATA_W-1];
                unique case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        top_next   = alu_y[DATA_W-1:0];
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                    OP_MUL:
                    begin
                        state_next = S_MUL;
                    end
                    OP_DIV:
                    begin
                        if (ram_rd_data == '0)
                        begin
                            error_next = ST_DIVZERO;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DIVA;
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                if (opb_reg[0])
                begin
                    acc_next = alu_y[DATA_W-1:0];
                end
                opa_next  = {opa_reg[DATA_W-2:0], 1'b0};
                opb_next  = {1'b0, opb_reg[DATA_W-1:1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    top_next   = opb_reg[0] ? alu_y[DATA_W-1:0] : acc_reg;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DIVA:
            begin
                if (opa_reg[DATA_W-1])
                begin
                    opa_next = alu_y[DATA_W-1:0];
                end
                state_next = S_DIVB;
            end
            S_DIVB:
            begin
                if (opb_reg[DATA_W-1])
                begin
                    opb_next = alu_y[DATA_W-1:0];
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!alu_y[DATA_W])
                begin
                    acc_next = alu_y[DATA_W-1:0];
                end
                else
                begin
                    acc_next = alu_a[DATA_W-1:0];
                end
                opa_next  = {opa_reg[DATA_W-2:0], ~alu_y[DATA_W]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                top_next   = neg_reg ? alu_y[DATA_W-1:0] : opa_reg;
                count_next = count_reg - CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE, S_WAIT:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next.result_value = (count_reg != '0) ? top_reg : '0;
                    if (error_reg != ST_OK)
                    begin
                        out_next.status = error_reg;
                    end
                    else if (count_reg != CNT_W'(1))
                    begin
                        out_next.status = ST_MALFORMED;
                    end
                    else
                    begin
                        out_next.status = ST_OK;
                    end
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    error_next     = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            error_reg     <= ST_OK;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        top_reg  <= top_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        op_reg   <= op_next;
        last_reg <= last_next;
    end

    `PFX_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `PFX_ASSERT_NOW(a_step_idle, step_reg != '0, state_reg == S_MUL || state_reg == S_DIV, "step counter running outside an iteration")
    `PFX_ASSERT_NEXT(a_end_clears, (state_reg == S_DONE || state_reg == S_WAIT) && last_reg && out_free, count_reg == '0 && error_reg == ST_OK && out_valid_reg, "final token did not publish and clear")
    `PFX_ASSERT_NEXT(a_error_sticky, error_reg != ST_OK && state_reg != S_DONE && state_reg != S_WAIT, error_reg == $past(error_reg), "error changed inside an expression")
    `PFX_ASSERT_NOW(a_status_code, out_valid_reg, out_reg.status <= ST_MALFORMED, "status code out of range")

endmodule

/* rtl/core/pfx_eval_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// depends on pfx_eval_pkg for default sizes
module pfx_eval_ram #(
    parameter int WIDTH = pfx_eval_pkg::DATA_W,
    parameter int DEPTH = pfx_eval_pkg::STACK_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/tb_prefix_expression_evaluator.sv */
// self-checking testbench for the prefix expression evaluator, token stream in, result words out
// predicts every result with its own stack model; depends on pfx_eval_pkg and the evaluator rtl
`timescale 1ns / 100ps

module tb_prefix_expression_evaluator;

    import pfx_eval_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_TOKENS = 300;
    localparam int DRAIN_CYCLES = 100;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    class expr_checker;
        logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH_DEF];
        int unsigned              depth_now;
        logic [STATUS_W-1:0]      err_now;
        pfx_eval_out_t            pending_results[$];
        int unsigned              errors;
        int unsigned              tokens_seen;
        int unsigned              results_seen;
        int unsigned              status_hits[5];

        function new();
            depth_now = 0;
            err_now   = ST_OK;
        endfunction

        function logic signed [DATA_W-1:0] quotient(logic signed [DATA_W-1:0] num,
                                                    logic signed [DATA_W-1:0] den);
            if (num == VAL_MIN && den == -1)
                return num;
            return num / den;
        endfunction

        function void take_token(pfx_eval_in_t word);
            logic signed [DATA_W-1:0] lhs;
            logic signed [DATA_W-1:0] rhs;
            logic signed [DATA_W-1:0] res;
            pfx_eval_out_t            r;
            bit                       done;
            tokens_seen++;
            if (err_now == ST_OK) begin
                if (word.mode == MODE_OP) begin
                    if (depth_now < 2) begin
                        err_now = ST_UNDERFLOW;
                    end else begin
                        lhs  = stack_mem[depth_now-1];
                        rhs  = stack_mem[depth_now-2];
                        done = 1'b1;
                        case (word.op_code)
                            OP_ADD: res = lhs + rhs;
                            OP_SUB: res = lhs - rhs;
                            OP_MUL: res = lhs * rhs;
                            OP_DIV:
                            begin
                                if (rhs == 0) begin
                                    err_now = ST_DIVZERO;
                                    done    = 1'b0;
                                end else begin
                                    res = quotient(lhs, rhs);
                                end
                            end
                        endcase
                        if (done) begin
                            depth_now--;
                            stack_mem[depth_now-1] = res;
                        end
                    end
                end else if (depth_now >= STACK_DEPTH_DEF) begin
                    err_now = ST_OVERFLOW;
                end else begin
                    stack_mem[depth_now] = word.operand_value;
                    depth_now++;
                end
            end
            if (word.last_token) begin
                if (err_now != ST_OK)
                    r.status = err_now;
                else if (depth_now != 1)
                    r.status = ST_MALFORMED;
                else
                    r.status = ST_OK;
                r.result_value = (depth_now == 0) ? '0 : stack_mem[depth_now-1];
                pending_results = {pending_results, r};
                depth_now = 0;
                err_now   = ST_OK;
            end
        endfunction

        function void check_result(pfx_eval_out_t got);
            pfx_eval_out_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, got value %0d status %0d",
                         $time, got.result_value, got.status);
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            if (want.status < 5)
                status_hits[want.status]++;
            if (got.result_value !== want.result_value) begin
                errors++;
                $display("%0t: result_value mismatch, expected %0d, got %0d",
                         $time, want.result_value, got.result_value);
            end
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          token_valid;
    logic          token_stall;
    pfx_eval_in_t  token;
    logic          result_valid;
    logic          result_stall;
    pfx_eval_out_t result;

    expr_checker sb = new();
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned tokens_sent;
    int unsigned cycles;

    prefix_expression_evaluator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token        (token),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(result);
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return 1;
            2: return -1;
            3: return VAL_MIN;
            4: return VAL_MAX;
            5, 6: return $signed(DATA_W'($urandom_range(40))) - 20;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // the field that the token kind ignores is filled with noise
    task automatic send_token(input logic mode, input logic signed [DATA_W-1:0] value,
                              input logic [1:0] op, input logic last);
        pfx_eval_in_t word;
        word.mode          = mode;
        word.operand_value = (mode == MODE_PUSH) ? value : {$urandom, $urandom};
        word.op_code       = (mode == MODE_OP) ? op : 2'($urandom_range(3));
        word.last_token    = last;
        while ($urandom_range(99) < send_idle_pct) begin
            token_valid <= 1'b0;
            @(posedge clk);
        end
        token_valid <= 1'b1;
        token       <= word;
        @(posedge clk);
        while (token_stall)
            @(posedge clk);
        sb.take_token(word);
        tokens_sent++;
    endtask

    // well-formed reversed prefix expression, optionally all pushes first, optionally cut short
    task automatic send_expression(input int n_ops, input bit deep, input int cut_at);
        int  pushes_left;
        int  ops_left;
        int  depth;
        int  idx;
        int  total;
        bit  do_push;
        logic last;
        pushes_left = n_ops + 1;
        ops_left    = n_ops;
        depth       = 0;
        idx         = 0;
        total       = 2 * n_ops + 1;
        while (pushes_left + ops_left > 0) begin
            do_push = pushes_left > 0 && (depth < 2 || ops_left == 0 || deep ||
                      (depth < STACK_DEPTH_DEF && $urandom_range(1) == 1));
            last = (idx == total - 1) || (idx == cut_at);
            if (do_push) begin
                send_token(MODE_PUSH, pick_value(), OP_ADD, last);
                pushes_left--;
                depth++;
            end else begin
                send_token(MODE_OP, '0, 2'($urandom_range(3)), last);
                ops_left--;
                depth--;
            end
            if (idx == cut_at)
                break;
            idx++;
        end
    endtask

    task automatic drain_results();
        token_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_token(MODE_PUSH, VAL_MAX, OP_ADD, 1'b1);
        // operator pops top as left operand
        send_token(MODE_PUSH, 7, OP_ADD, 1'b0);
        send_token(MODE_PUSH, 3, OP_ADD, 1'b0);
        send_token(MODE_OP, '0, OP_ADD, 1'b1);
        send_token(MODE_PUSH, 2, OP_ADD, 1'b0);
        send_token(MODE_PUSH, 9, OP_ADD, 1'b0);
        send_token(MODE_OP, '0, OP_SUB, 1'b1);
        send_token(MODE_PUSH, 2, OP_ADD, 1'b0);
        send_token(MODE_PUSH, VAL_MAX, OP_ADD, 1'b0);
        send_token(MODE_OP, '0, OP_MUL, 1'b1);
        // most negative over minus one wraps
        send_token(MODE_PUSH, -1, OP_ADD, 1'b0);
        send_token(MODE_PUSH, VAL_MIN, OP_ADD, 1'b0);
        send_token(MODE_OP, '0, OP_DIV, 1'b1);
        // truncation toward zero
        send_token(MODE_PUSH, 2, OP_ADD, 1'b0);
        send_token(MODE_PUSH, -7, OP_ADD, 1'b0);
        send_token(MODE_OP, '0, OP_DIV, 1'b1);
        send_token(MODE_PUSH, 0, OP_ADD, 1'b0);
        send_token(MODE_PUSH, 5, OP_ADD, 1'b0);
        send_token(MODE_OP, '0, OP_DIV, 1'b1);
        // underflow on empty stack reports zero
        send_token(MODE_OP, '0, OP_ADD, 1'b1);
        // sticky underflow, later push is skipped
        send_token(MODE_PUSH, 4, OP_ADD, 1'b0);
        send_token(MODE_OP, '0, OP_SUB, 1'b0);
        send_token(MODE_PUSH, 1, OP_ADD, 1'b1);
        // two values left at the end
        send_token(MODE_PUSH, 1, OP_ADD, 1'b0);
        send_token(MODE_PUSH, 2, OP_ADD, 1'b1);
    endtask

    task automatic run_random_phase();
        int unsigned start;
        int          pick;
        int          n;
        start = tokens_sent;
        while (tokens_sent - start < PHASE_TOKENS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
                send_expression(n, 1'b0, -1);
            end else if (pick < 85) begin
                n = $urandom_range(1, 6);
                send_expression(n, 1'b0, $urandom_range(0, 2 * n - 1));
            end else if (pick < 87) begin
                send_expression($urandom_range(62, 65), 1'b1, -1);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_token(1'($urandom_range(1)), {$urandom, $urandom},
                               2'($urandom_range(3)), $urandom_range(3) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        token_valid    = 1'b0;
        token          = '0;
        send_idle_pct  = 13;
        recv_stall_pct = 75;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        // a full stack, then one push too many
        send_expression(STACK_DEPTH_DEF - 1, 1'b1, -1);
        send_expression(STACK_DEPTH_DEF, 1'b1, -1);
        run_random_phase();
        drain_results();

        send_idle_pct  = 75;
        recv_stall_pct = 13;
        run_random_phase();
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_phase();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d tokens and %0d result words in %0d cycles",
                 sb.tokens_seen, sb.results_seen, cycles);
        $display("statuses: ok %0d, underflow %0d, overflow %0d, div by zero %0d, malformed %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_UNDERFLOW], sb.status_hits[ST_OVERFLOW],
                 sb.status_hits[ST_DIVZERO], sb.status_hits[ST_MALFORMED]);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pfx_eval_pkg.sv
rtl/core/pfx_eval_ram.sv
rtl/core/prefix_expression_evaluator.sv
tb/tb_prefix_expression_evaluator.sv
